>>> sv/rase_pkg.sv
// ----------------------------------------------------------------------------
// rase_pkg
// Shared types and constants for the rotary angle speed estimator.
// ----------------------------------------------------------------------------
package rase_pkg;

    localparam int ANGLE_W  = 12;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int SPEED_W  = 23;
    // shared divider width: covers |delta|*3750 (23 b) and 7*s + 3*v (27 b)
    localparam int DIV_W    = 27;
    localparam int DIV_CNT_W = 5;

    localparam logic [ANGLE_W-1:0] HALF_TURN   = 12'd2048;
    localparam logic [ANGLE_W-1:0] SPEED_SCALE = 12'd3750;
    localparam logic [TIME_W-1:0]  EMA_DIVISOR = 32'd10;

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd50;
    localparam logic [CFG_W-1:0] NOISE_FLOOR_RST  = 16'd256;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_NOISE_FLOOR  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELAP,
        S_CHECK,
        S_LAUNCH1,
        S_WAIT1,
        S_MIX,
        S_LAUNCH2,
        S_WAIT2,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] min_interval_ms;
        logic [CFG_W-1:0] noise_floor_q8;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> sv/rase_sdiv.sv
// ----------------------------------------------------------------------------
// rase_sdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rase_sdiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rase_pkg::t_div_req  i_req,
    output rase_pkg::t_div_rsp  o_rsp
);

    logic [rase_pkg::TIME_W-1:0]    r_rem,  n_rem;
    logic [rase_pkg::DIV_W-1:0]     r_quo,  n_quo;
    logic [rase_pkg::TIME_W-1:0]    r_dvs;
    logic [rase_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [rase_pkg::TIME_W:0]      trial;
    logic [rase_pkg::TIME_W:0]      diff;

    // shift next dividend bit into the partial remainder and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[rase_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        if (!diff[rase_pkg::TIME_W]) begin
            n_rem = diff[rase_pkg::TIME_W-1:0];
            n_quo = {r_quo[rase_pkg::DIV_W-2:0], 1'b1};
        end else begin
            n_rem = trial[rase_pkg::TIME_W-1:0];
            n_quo = {r_quo[rase_pkg::DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rase_pkg::DIV_CNT_W'(rase_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> sv/rase_regs.sv
// ----------------------------------------------------------------------------
// rase_regs
// APB register file: minimum interval and noise floor.
// ----------------------------------------------------------------------------
module rase_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output rase_pkg::t_cfg                 o_cfg
);

    logic [rase_pkg::CFG_W-1:0] r_min_interval;
    logic [rase_pkg::CFG_W-1:0] r_noise_floor;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // word aligned: byte lanes in paddr[1:0] are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= rase_pkg::MIN_INTERVAL_RST;
            r_noise_floor  <= rase_pkg::NOISE_FLOOR_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                rase_pkg::REG_MIN_INTERVAL: r_min_interval <= pwdata[rase_pkg::CFG_W-1:0];
                rase_pkg::REG_NOISE_FLOOR:  r_noise_floor  <= pwdata[rase_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rase_pkg::REG_MIN_INTERVAL: prdata = {16'd0, r_min_interval};
            rase_pkg::REG_NOISE_FLOOR:  prdata = {16'd0, r_noise_floor};
            default:                    prdata = {paddr[1:0] == 2'd0 ? 30'd0 : 30'd0, 2'd0};
        endcase
    end

    assign o_cfg.min_interval_ms = r_min_interval;
    assign o_cfg.noise_floor_q8  = r_noise_floor;

endmodule

>>> sv/rotary_angle_speed_estimator.sv
// ----------------------------------------------------------------------------
// rotary_angle_speed_estimator
// Shaft speed from absolute angle and ms timestamps, with EMA smoothing.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transfer per sample, tdata = {pad, time_ms,
//   angle_count}. Output stream (m_axis): one transfer per input sample,
//   tdata = filtered_speed_q8 (Q15.8 rpm), tuser = accepted.
//   APB port: reg 0 (addr 0x0) min_interval_ms, reg 1 (addr 0x4)
//   noise_floor_q8. Write only while no sample is in flight.
// Sequence:
//   A sample whose elapsed time is too short goes from ELAP through CHECK
//   straight to OUT; the next sample is taken once the engine is back in IDLE.
//   An accepted sample makes two passes through the shared bit-serial
//   divider, first |delta|*3750/elapsed, then the 7:3 blend divided by 10,
//   before its result is loaded in OUT. One sample at a time: the next
//   sample is taken only after the result of the last one has been loaded.
// Reset:
//   last angle, last time and smoothed speed clear to zero; registers take
//   50 ms and 256. No result is pending after reset.
// Stall:
//   Results sit in an output register; the next sample is taken while one
//   waits. A finished result that finds the register still full holds the
//   engine until the receiver takes the waiting transfer.
// ----------------------------------------------------------------------------
module rotary_angle_speed_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [11:0] angle_count, [43:12] time_ms, [47:44] zero
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [22:0] filtered_speed_q8, [23] zero
    output logic        o_m_axis_tuser,   // [0] accepted
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = rase_pkg::ANGLE_W;
    localparam int TW = rase_pkg::TIME_W;
    localparam int SW = rase_pkg::SPEED_W;
    localparam int DW = rase_pkg::DIV_W;

    rase_pkg::t_state   r_state, n_state;
    rase_pkg::t_cfg     cfg;
    rase_pkg::t_div_req div_req;
    rase_pkg::t_div_rsp div_rsp;

    // sample being processed
    logic [AW-1:0] r_angle;
    logic [TW-1:0] r_time;
    logic [TW-1:0] r_elapsed;
    logic [AW-1:0] r_mag;
    logic [DW-1:0] r_num;
    logic [DW-1:0] r_mix;
    logic          r_acc;

    // state carried between samples
    logic [AW-1:0] r_last_angle;
    logic [TW-1:0] r_last_time;
    logic [SW-1:0] r_smooth;

    // output register
    logic          r_out_valid;
    logic [SW-1:0] r_out_speed;
    logic          r_out_acc;

    logic          in_xfer;
    logic          out_xfer;
    logic          out_load;
    logic          out_free;
    logic          long_enough;
    logic [AW-1:0] d_raw;
    logic [AW-1:0] d_mag;
    logic [SW-1:0] raw_speed;
    logic [SW-1:0] gated_speed;

    rase_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rase_sdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_valid && i_m_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // angle change mod 4096, folded into half a turn; a tie keeps 2048
    assign d_raw = r_angle - r_last_angle;
    assign d_mag = (d_raw <= rase_pkg::HALF_TURN) ? d_raw
                                                  : AW'((AW+1)'(1 << AW) - (AW+1)'(d_raw));

    assign long_enough = r_elapsed > {16'd0, cfg.min_interval_ms};

    // raw speed never exceeds 2048*3750, which fits 23 bits
    assign raw_speed   = div_rsp.quotient[SW-1:0];
    assign gated_speed = (raw_speed < SW'(cfg.noise_floor_q8)) ? '0 : raw_speed;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rase_pkg::S_IDLE:    if (in_xfer) n_state = rase_pkg::S_ELAP;
            rase_pkg::S_ELAP:    n_state = rase_pkg::S_CHECK;
            rase_pkg::S_CHECK:   n_state = long_enough ? rase_pkg::S_LAUNCH1 : rase_pkg::S_OUT;
            rase_pkg::S_LAUNCH1: n_state = rase_pkg::S_WAIT1;
            rase_pkg::S_WAIT1:   if (div_rsp.done) n_state = rase_pkg::S_MIX;
            rase_pkg::S_MIX:     n_state = rase_pkg::S_LAUNCH2;
            rase_pkg::S_LAUNCH2: n_state = rase_pkg::S_WAIT2;
            rase_pkg::S_WAIT2:   if (div_rsp.done) n_state = rase_pkg::S_UPDATE;
            rase_pkg::S_UPDATE:  n_state = rase_pkg::S_OUT;
            rase_pkg::S_OUT:     if (out_free) n_state = rase_pkg::S_IDLE;
            default:             n_state = rase_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        o_s_axis_tready  = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_num;
        div_req.divisor  = r_elapsed;
        unique case (r_state)
            // no transfer while reset is held
            rase_pkg::S_IDLE:    o_s_axis_tready = i_rst_n;
            rase_pkg::S_LAUNCH1: div_req.start = 1'b1;
            rase_pkg::S_LAUNCH2: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_mix;
                div_req.divisor  = rase_pkg::EMA_DIVISOR;
            end
            rase_pkg::S_OUT:     out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rase_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_angle <= i_s_axis_tdata[AW-1:0];
            r_time  <= i_s_axis_tdata[AW+TW-1:AW];
        end
        if (r_state == rase_pkg::S_ELAP) begin
            r_elapsed <= r_time - r_last_time;
            r_mag     <= d_mag;
        end
        if (r_state == rase_pkg::S_CHECK) begin
            r_num <= DW'(r_mag) * DW'(rase_pkg::SPEED_SCALE);
            r_acc <= long_enough;
        end
        // 7*s + 3*v, at most 10 * 7680000
        if (r_state == rase_pkg::S_MIX) begin
            r_mix <= DW'({r_smooth, 3'b000}) - DW'(r_smooth)
                   + DW'({gated_speed, 1'b0}) + DW'(gated_speed);
        end
        if (out_load) begin
            r_out_speed <= r_smooth;
            r_out_acc   <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_last_time  <= '0;
            r_smooth     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == rase_pkg::S_UPDATE) begin
                r_smooth     <= div_rsp.quotient[SW-1:0];
                r_last_angle <= r_angle;
                r_last_time  <= r_time;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_speed};
    assign o_m_axis_tuser  = r_out_acc;

endmodule

>>> sv/rase_chk.sv
// ----------------------------------------------------------------------------
// rase_chk
// Port-level checks for the rotary angle speed estimator.
// ----------------------------------------------------------------------------
module rase_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        pready
);

    // nothing pending right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // smoothed speed never exceeds the largest raw speed, pad bit stays zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[23] && (o_m_axis_tdata[22:0] <= 23'd7680000))
        else $error("filtered speed out of range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind rotary_angle_speed_estimator rase_chk u_rase_chk (.*);

>>> bench/rase_checker.sv
// ----------------------------------------------------------------------------
// rase_checker
// Watches the sample stream, the result stream and the APB port of the speed
// estimator. Keeps its own estimate of shaft speed and compares every result
// transfer with the oldest pending estimate.
// ----------------------------------------------------------------------------
module rase_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,   // [11:0] angle_count, [43:12] time_ms, [47:44] zero
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [22:0] filtered_speed_q8, [23] zero
    input  logic        i_m_tuser,   // [0] accepted
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = rase_pkg::ANGLE_W;
    localparam int TW = rase_pkg::TIME_W;
    localparam int SW = rase_pkg::SPEED_W;
    localparam int CW = rase_pkg::CFG_W;

    localparam int TURN_COUNTS = 2 * int'(rase_pkg::HALF_TURN);
    localparam int KEEP_WEIGHT = 7;
    localparam int NEW_WEIGHT  = 3;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [SW-1:0] speed;
        logic          accepted;
    } t_speed_rpt;

    t_speed_rpt    speed_rpt_due[$];
    t_speed_rpt    oldest;
    logic [CW-1:0] min_interval;
    logic [CW-1:0] noise_floor;
    logic [AW-1:0] prev_angle;
    logic [TW-1:0] prev_stamp;
    logic [SW-1:0] smooth_speed;
    int            fail_total;

    assign o_fail_count = fail_total;

    // Advance the speed estimate by one sample and return the result it yields.
    function automatic t_speed_rpt advance_estimate(input logic [AW-1:0] angle,
                                                    input logic [TW-1:0] stamp);
        logic [TW-1:0] elapsed;
        int            delta;
        int unsigned   mag;
        logic [63:0]   raw;
        logic [63:0]   blend;
        t_speed_rpt    rpt;
        elapsed      = stamp - prev_stamp;
        rpt.accepted = 1'b0;
        if (elapsed > TW'(min_interval)) begin
            delta = int'(angle) - int'(prev_angle);
            // wrap into half a turn; an exact half turn keeps its sign
            if (delta < -int'(rase_pkg::HALF_TURN)) delta += TURN_COUNTS;
            if (delta > int'(rase_pkg::HALF_TURN))  delta -= TURN_COUNTS;
            mag = (delta < 0) ? -delta : delta;
            raw = (64'(mag) * 64'(rase_pkg::SPEED_SCALE)) / 64'(elapsed);
            if (raw < 64'(noise_floor)) raw = 64'd0;
            blend = (64'(KEEP_WEIGHT) * 64'(smooth_speed) + 64'(NEW_WEIGHT) * raw)
                    / 64'(rase_pkg::EMA_DIVISOR);
            smooth_speed = blend[SW-1:0];
            prev_angle   = angle;
            prev_stamp   = stamp;
            rpt.accepted = 1'b1;
        end
        rpt.speed = smooth_speed;
        return rpt;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_interval = rase_pkg::MIN_INTERVAL_RST;
            noise_floor  = rase_pkg::NOISE_FLOOR_RST;
            prev_angle   = '0;
            prev_stamp   = '0;
            smooth_speed = '0;
            speed_rpt_due.delete();
            fail_total   = 0;
        end else begin
            // a result leaving now belongs to a sample taken at an earlier edge
            if (i_m_tvalid && i_m_tready) begin
                if (speed_rpt_due.size() == 0) begin
                    if (fail_total < REPORT_MAX)
                        $display("%0t: unexpected result: speed %0d accepted %0b",
                                 $realtime, i_m_tdata[SW-1:0], i_m_tuser);
                    fail_total++;
                end else begin
                    oldest = speed_rpt_due.pop_front();
                    if (i_m_tdata[SW-1:0] !== oldest.speed ||
                        i_m_tuser !== oldest.accepted) begin
                        if (fail_total < REPORT_MAX)
                            $display("%0t: mismatch: expected %0d %0b, got %0d %0b",
                                     $realtime, oldest.speed, oldest.accepted,
                                     i_m_tdata[SW-1:0], i_m_tuser);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                speed_rpt_due.push_back(advance_estimate(i_s_tdata[AW-1:0],
                                                         i_s_tdata[AW +: TW]));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    rase_pkg::REG_MIN_INTERVAL: min_interval = i_pwdata[CW-1:0];
                    rase_pkg::REG_NOISE_FLOOR:  noise_floor  = i_pwdata[CW-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= speed_rpt_due.size();
    end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the rotary angle speed estimator. A short directed
// run covers the interval boundary, half-turn ties, angle and timestamp wrap
// and the fastest speed; then random phases under several register settings
// feed mostly well-formed sample sequences, with bursty input and a stalling
// receiver. Checking is done by rase_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = rase_pkg::ANGLE_W;
    localparam int TW = rase_pkg::TIME_W;
    localparam int CW = rase_pkg::CFG_W;

    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 100;     // engine takes one sample at a time
    localparam int FILL_HOLD    = 600;     // long receiver hold-off, in cycles
    localparam int MODE_CYCLES  = 50;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;                  // [11:0] angle_count, [43:12] time_ms, [47:44] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;                  // [22:0] filtered_speed_q8, [23] zero
    logic        m_tuser;                  // [0] accepted
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          fail_count;
    bit          fill_up;                  // asks the receiver for its long hold-off
    int          burst_left;
    int          cur_min;                  // current interval register, for shaping

    logic [AW-1:0] a_cursor;
    logic [TW-1:0] t_cursor;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rotary_angle_speed_estimator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    rase_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // APB write: setup cycle, access cycle, done when pready is seen.
    // Upper data bits carry junk; the registers are 16 bits wide.
    task automatic cfg_write(input logic reg_idx, input logic [CW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == rase_pkg::REG_MIN_INTERVAL) cur_min = value;
    endtask

    // One sample transfer. Within a burst tvalid stays high from one
    // sample to the next; at the end of a burst it drops for a random gap.
    task automatic send_sample(input logic [AW-1:0] angle,
                               input logic [TW-1:0] stamp);
        int gap;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, stamp, angle};
        do @(posedge i_clk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Stop offering and wait for every pending result; the block is idle then.
    task automatic settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: ready pattern switches to a random mode after a random run of up
    // to MODE_CYCLES, plus one long hold-off on request so the block fills up and stalls its input.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        m_tready  = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (fill_up && !hold_done) begin
                hold_left = FILL_HOLD;
                hold_done = 1;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(1, MODE_CYCLES);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int min_tab   [PHASES];
        int floor_tab [PHASES];
        int pick;
        int step;
        int n;
        int p;
        int k;

        // every input known from time zero
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fill_up    = 0;
        burst_left = 0;
        cur_min    = rase_pkg::MIN_INTERVAL_RST;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed, reset settings (50 ms, floor 256) ----
        send_sample(12'd100,  32'd10);          // first sample vs angle 0 / time 0, too soon
        send_sample(12'd100,  32'd50);          // elapsed equals the interval: rejected
        send_sample(12'd100,  32'd51);          // just over: accepted
        send_sample(12'd2148, 32'd52);          // one ms later: rejected
        send_sample(12'd2148, 32'd102);         // +half turn exactly
        send_sample(12'd100,  32'd153);         // -half turn exactly
        send_sample(12'd4000, 32'd204);         // raw +3900 wraps backward
        send_sample(12'd50,   32'd255);         // raw -3950 wraps forward
        send_sample(12'd50,   32'd306);         // no motion
        send_sample(12'd51,   32'd357);         // tiny speed, under noise floor
        send_sample(12'd4095, 32'hFFFF_FFF0);   // very long interval
        send_sample(12'd0,    32'h0000_0040);   // timestamp wraps through zero
        send_sample(12'd2000, 32'h0000_0010);   // timestamp goes backward
        settle();

        // ---- directed, zero interval and zero floor: fastest speed ----
        cfg_write(rase_pkg::REG_MIN_INTERVAL, 16'd0);
        cfg_write(rase_pkg::REG_NOISE_FLOOR,  16'd0);
        for (k = 0; k < 3; k++) begin
            send_sample(12'd4048, 32'h11 + 2 * k);
            send_sample(12'd2000, 32'h12 + 2 * k);
        end
        send_sample(12'd4048, 32'h16);          // same stamp: zero elapsed, rejected
        settle();

        // ---- directed, both registers at maximum ----
        cfg_write(rase_pkg::REG_MIN_INTERVAL, 16'hFFFF);
        cfg_write(rase_pkg::REG_NOISE_FLOOR,  16'hFFFF);
        send_sample(12'd0,    32'h16 + 32'd65535);
        send_sample(12'd4048, 32'h16 + 32'd65536);
        send_sample(12'd4095, 32'hFFFF_FFFF);
        settle();

        // ---- random phases ----
        min_tab   = '{50,  0, 65535, 1,  0, 2,     0};
        floor_tab = '{256, 0, 65535, 0,  0, 65535, 0};
        min_tab[3]   = $urandom_range(1, 20);
        floor_tab[3] = $urandom_range(0, 4000);
        min_tab[4]   = $urandom_range(0, 300);
        floor_tab[4] = $urandom_range(0, 8000);
        floor_tab[6] = $urandom_range(0, 65535);
        a_cursor = 12'($urandom);
        t_cursor = $urandom;

        for (p = 0; p < PHASES; p++) begin
            cfg_write(rase_pkg::REG_MIN_INTERVAL, 16'(min_tab[p]));
            cfg_write(rase_pkg::REG_NOISE_FLOOR,  16'(floor_tab[p]));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 50) fill_up = 1;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // well-formed: enough time passed, plausible motion
                    if ($urandom_range(0, 3) == 0)
                        step = cur_min + 1 + $urandom_range(0, 3);
                    else
                        step = cur_min + 1 + $urandom_range(0, 2 * cur_min + 100);
                    case ($urandom_range(0, 3))
                        0:       a_cursor = a_cursor + 12'($urandom_range(0, 128)) - 12'd64;
                        1:       a_cursor = a_cursor + rase_pkg::HALF_TURN;
                        2:       a_cursor = 12'($urandom_range(0, 4095));
                        default: a_cursor = a_cursor + 12'($urandom_range(0, 16));
                    endcase
                    t_cursor = t_cursor + TW'(step);
                end else if (pick < 85) begin
                    // too soon after the last sample
                    step     = $urandom_range(0, cur_min);
                    t_cursor = t_cursor + TW'(step);
                    a_cursor = a_cursor + 12'($urandom_range(0, 255));
                end else if (pick < 93) begin
                    // clock jump, forward or backward
                    t_cursor = $urandom;
                    a_cursor = 12'($urandom);
                end else begin
                    // pure noise, cursors untouched
                    send_sample(12'($urandom), $urandom);
                    continue;
                end
                send_sample(a_cursor, t_cursor);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/rase_pkg.sv
sv/rase_sdiv.sv
sv/rase_regs.sv
sv/rotary_angle_speed_estimator.sv
sv/rase_chk.sv
bench/rase_checker.sv
bench/testbench.sv
